@@ src/assert_macros.svh @@
// Assertion macros shared by the averager RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ACRA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, during reset too.
`define ACRA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/acra_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and register map of the count-rate averager.
// No dependencies; the controller, datapath and top level import this package.
package acra_pkg;

    localparam int COUNT_W     = 20;
    localparam int FRAC_W      = 8;
    localparam int RATE_W      = COUNT_W + FRAC_W;
    localparam int FACTOR_W    = 24;
    localparam int FACTOR_FRAC = 16;
    localparam int BG_W        = 32;
    localparam int UNIT_W      = 2;
    localparam int DISP_W      = 32;
    localparam int CNT_W       = 3;
    localparam int V_W         = RATE_W + FACTOR_W - FACTOR_FRAC;
    localparam int UNIT1_NUM   = 116;
    localparam int UNIT1_DEN   = 100;
    localparam int UNIT_PROD_W = V_W + $clog2(UNIT1_NUM + 1);
    localparam int RATIO_DEN   = 10;
    localparam int RISE_NUM    = 13;
    localparam int FALL_NUM    = 7;
    localparam int CMP_W       = RATE_W + 4;

    localparam int DEF_WINDOW_LENGTH = 60;
    localparam int DEF_FAST_LIMIT    = 5;

    localparam int DATA_W     = 32;
    localparam int REG_ADDR_W = 4;

    localparam logic [COUNT_W-1:0]  THRESHOLD_RST  = COUNT_W'(10);
    localparam logic [FACTOR_W-1:0] FACTOR_RST     = FACTOR_W'(65536);
    localparam logic [BG_W-1:0]     BACKGROUND_RST = '0;

    typedef enum logic [1:0] {
        REG_THRESHOLD  = 2'd0,
        REG_FACTOR     = 2'd1,
        REG_BACKGROUND = 2'd2,
        REG_UNIT       = 2'd3
    } reg_idx_t;

    typedef enum logic [UNIT_W-1:0] {
        UNIT_CPS    = 2'd0,
        UNIT_SVH    = 2'd1,
        UNIT_SCALED = 2'd2
    } unit_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_FILL,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_MUL,
        ST_SCALE,
        ST_UNIT_START,
        ST_UNIT_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  threshold;
        logic [FACTOR_W-1:0] factor;
        logic [BG_W-1:0]     background;
        logic [UNIT_W-1:0]   unit;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic clear_step;
        logic fill_step;
        logic ring_write;
        logic div_start;
        logic div_unit;
        logic mul_step;
        logic scale_step;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        logic fill_last;
        logic refill;
        logic unit_one;
        logic div_idle;
        logic result_free;
    } status_t;

endpackage

@@ src/acra_div.sv @@
`timescale 1ns / 1ps
// Divider by one of two constants: multiply by a rounded-up reciprocal, one
// slice of the reciprocal per cycle, and keep the upper product bits.
// Depends only on assert_macros.svh.
`include "assert_macros.svh"

module acra_div #(
    parameter int DIVIDEND_W = 43,
    parameter int DIVISOR_A  = 60,
    parameter int DIVISOR_B  = 100
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  sel_b,
    input  logic [DIVIDEND_W-1:0] dividend,
    output logic                  idle,
    output logic [DIVIDEND_W-1:0] quotient
);

    // shift wide enough that floor(x * recip / 2**SHIFT) equals floor(x / d)
    // for every dividend of DIVIDEND_W bits
    localparam int DIVISOR_MAX = (DIVISOR_A > DIVISOR_B) ? DIVISOR_A : DIVISOR_B;
    localparam int SHIFT       = DIVIDEND_W + $clog2(DIVISOR_MAX);
    localparam int PART_W      = 16;
    localparam int PARTS       = (SHIFT + PART_W - 1) / PART_W;
    localparam int RECIP_W     = PARTS * PART_W;
    localparam int ACC_W       = DIVIDEND_W + RECIP_W;
    localparam int PPROD_W     = DIVIDEND_W + PART_W;
    localparam int STEP_W      = $clog2(PARTS + 1);
    localparam logic [63:0] RECIP_A =
        ((64'd1 << SHIFT) + 64'(DIVISOR_A - 1)) / 64'(DIVISOR_A);
    localparam logic [63:0] RECIP_B =
        ((64'd1 << SHIFT) + 64'(DIVISOR_B - 1)) / 64'(DIVISOR_B);

    logic [STEP_W-1:0]     cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] x_reg;
    logic [RECIP_W-1:0]    recip_reg;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [PPROD_W-1:0]    part_prod;

    // Horner step: shift the accumulator up, add the product with the next slice
    always_comb
    begin
        part_prod = PPROD_W'(x_reg) * PPROD_W'(recip_reg[RECIP_W-1 -: PART_W]);
        acc_next  = {acc_reg[ACC_W-PART_W-1:0], PART_W'(0)} + ACC_W'(part_prod);
        cnt_next  = cnt_reg - STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= STEP_W'(PARTS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg     <= dividend;
            recip_reg <= sel_b ? RECIP_W'(RECIP_B) : RECIP_W'(RECIP_A);
            acc_reg   <= '0;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg   <= acc_next;
            recip_reg <= {recip_reg[RECIP_W-PART_W-1:0], PART_W'(0)};
        end
    end

    assign idle     = (cnt_reg == '0);
    assign quotient = acc_reg[SHIFT +: DIVIDEND_W];

    `ACRA_ASSERT(a_step_in_range, cnt_reg <= STEP_W'(PARTS), "divide step count out of range")
    `ACRA_ASSERT(a_start_when_idle, start |-> idle, "divide started while busy")

endmodule

@@ src/acra_dp.sv @@
`timescale 1ns / 1ps
// Datapath: rate ring memory, running sum, fast-response counters,
// display scaling and result register. Depends on acra_pkg and acra_div.
`include "assert_macros.svh"

module acra_dp
    import acra_pkg::*;
#(
    parameter int WINDOW_LENGTH = DEF_WINDOW_LENGTH,
    parameter int FAST_LIMIT    = DEF_FAST_LIMIT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  cfg_t               cfg,
    input  logic [COUNT_W-1:0] pulse_count,
    input  logic               result_ready,
    output logic               result_valid,
    output logic [RATE_W-1:0]  average_rate,
    output logic [DISP_W-1:0]  display_value,
    output logic               window_refilled
);

    localparam int IDX_W   = $clog2(WINDOW_LENGTH);
    localparam int SUM_W   = RATE_W + IDX_W;
    localparam int DIV_W   = (SUM_W > UNIT_PROD_W) ? SUM_W : UNIT_PROD_W;
    localparam int PROD_W  = RATE_W + FACTOR_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LENGTH - 1);
    localparam logic [CNT_W:0]   LIMIT    = (CNT_W + 1)'(FAST_LIMIT);

    // ring storage and its registered read port
    logic [RATE_W-1:0] ring_mem [WINDOW_LENGTH];
    logic [RATE_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_addr;
    logic [RATE_W-1:0] mem_wdata;

    logic [IDX_W-1:0]  wp_reg, fill_idx_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [RATE_W-1:0] prev_avg_reg;
    logic [CNT_W-1:0]  rise_cnt_reg, fall_cnt_reg, ret_cnt_reg;
    logic [CNT_W-1:0]  rise_cnt_next, fall_cnt_next, ret_cnt_next;

    logic [RATE_W-1:0] rate_reg, write_val_reg;
    logic              refill_reg;
    logic [RATE_W-1:0] avg_reg;
    logic [V_W-1:0]    v_reg, scaled_reg;
    logic [UNIT_PROD_W-1:0] unit_prod_reg;

    logic              result_valid_reg;
    logic [RATE_W-1:0] avg_out_reg;
    logic [DISP_W-1:0] disp_out_reg;
    logic              refilled_out_reg;

    // decision terms for the item being accepted
    logic [RATE_W-1:0] rate_in, thr_rate;
    logic [CMP_W-1:0]  r_scaled, p_rise, p_fall;
    logic              quiet, p_high, is_rise, is_fall;
    logic              hold_ret, hold_rise, hold_fall, hold, refill;
    logic [CNT_W:0]    n_ret, n_rise, n_fall;
    logic              full_ret, full_rise, full_fall;

    // divider hookup and display terms
    logic [DIV_W-1:0]  div_dividend, div_quotient;
    logic              div_idle;
    logic [RATE_W-1:0] quo_avg;
    logic [PROD_W-1:0] factor_prod;
    logic [V_W-1:0]    v_less_bg;
    logic [DISP_W-1:0] disp_comb;

    always_comb
    begin
        rate_in  = {pulse_count, FRAC_W'(0)};
        thr_rate = {cfg.threshold, FRAC_W'(0)};
        r_scaled = CMP_W'(rate_in) * CMP_W'(RATIO_DEN);
        p_rise   = CMP_W'(prev_avg_reg) * CMP_W'(RISE_NUM);
        p_fall   = CMP_W'(prev_avg_reg) * CMP_W'(FALL_NUM);
        quiet    = pulse_count < cfg.threshold;
        p_high   = prev_avg_reg > thr_rate;
        is_rise  = r_scaled > p_rise;
        is_fall  = r_scaled < p_fall;

        hold_ret  = quiet & p_high;
        hold_rise = !quiet & is_rise;
        hold_fall = !quiet & !is_rise & is_fall;
        hold      = hold_ret | hold_rise | hold_fall;

        n_ret     = {1'b0, ret_cnt_reg} + (CNT_W + 1)'(1);
        n_rise    = {1'b0, rise_cnt_reg} + (CNT_W + 1)'(1);
        n_fall    = {1'b0, fall_cnt_reg} + (CNT_W + 1)'(1);
        full_ret  = n_ret > LIMIT;
        full_rise = n_rise > LIMIT;
        full_fall = n_fall > LIMIT;
        refill    = (hold_ret & full_ret) | (hold_rise & full_rise) | (hold_fall & full_fall);

        // a held second counts up; crossing the limit clears the counter
        if (quiet)
        begin
            rise_cnt_next = '0;
            fall_cnt_next = '0;
            if (hold_ret)
                ret_cnt_next = full_ret ? '0 : n_ret[CNT_W-1:0];
            else
                ret_cnt_next = ret_cnt_reg;
        end
        else
        begin
            ret_cnt_next = '0;
            if (hold_rise)
            begin
                rise_cnt_next = full_rise ? '0 : n_rise[CNT_W-1:0];
                fall_cnt_next = '0;
            end
            else if (hold_fall)
            begin
                rise_cnt_next = '0;
                fall_cnt_next = full_fall ? '0 : n_fall[CNT_W-1:0];
            end
            else
            begin
                rise_cnt_next = rise_cnt_reg;
                fall_cnt_next = fall_cnt_reg;
            end
        end
    end

    // ring write port: clear sweep, refill sweep or single-entry update
    always_comb
    begin
        mem_we    = cmd.clear_step | cmd.fill_step | cmd.ring_write;
        mem_addr  = cmd.ring_write ? wp_reg : fill_idx_reg;
        mem_wdata = cmd.clear_step ? '0 : (cmd.fill_step ? rate_reg : write_val_reg);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[mem_addr] <= mem_wdata;
        rd_data_reg <= ring_mem[wp_reg];
    end

    always_comb
    begin
        if (cmd.fill_step)
            sum_next = SUM_W'(rate_reg) * SUM_W'(WINDOW_LENGTH);
        else
            sum_next = sum_reg - SUM_W'(rd_data_reg) + SUM_W'(write_val_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg           <= '0;
            fill_idx_reg     <= '0;
            sum_reg          <= '0;
            prev_avg_reg     <= '0;
            rise_cnt_reg     <= '0;
            fall_cnt_reg     <= '0;
            ret_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                rise_cnt_reg <= rise_cnt_next;
                fall_cnt_reg <= fall_cnt_next;
                ret_cnt_reg  <= ret_cnt_next;
            end
            if (cmd.clear_step || cmd.fill_step)
                fill_idx_reg <= (fill_idx_reg == LAST_IDX) ? '0 : fill_idx_reg + IDX_W'(1);
            if (cmd.ring_write)
                wp_reg <= (wp_reg == LAST_IDX) ? '0 : wp_reg + IDX_W'(1);
            if (cmd.ring_write || cmd.fill_step)
                sum_reg <= sum_next;
            if (cmd.mul_step)
                prev_avg_reg <= quo_avg;
            if (cmd.load_result)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    acra_div #(
        .DIVIDEND_W(DIV_W),
        .DIVISOR_A (WINDOW_LENGTH),
        .DIVISOR_B (UNIT1_DEN)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .sel_b   (cmd.div_unit),
        .dividend(div_dividend),
        .idle    (div_idle),
        .quotient(div_quotient)
    );

    always_comb
    begin
        div_dividend = cmd.div_unit ? DIV_W'(unit_prod_reg) : DIV_W'(sum_reg);
        quo_avg      = div_quotient[RATE_W-1:0];
        factor_prod  = PROD_W'(quo_avg) * PROD_W'(cfg.factor);
        v_less_bg    = (v_reg > V_W'(cfg.background)) ? v_reg - V_W'(cfg.background) : v_reg;

        unique case (cfg.unit)
            UNIT_CPS:
                disp_comb = DISP_W'(avg_reg);
            UNIT_SVH:
                disp_comb = (|div_quotient[DIV_W-1:DISP_W]) ? '1 : div_quotient[DISP_W-1:0];
            default:
                disp_comb = (|scaled_reg[V_W-1:DISP_W]) ? '1 : scaled_reg[DISP_W-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rate_reg      <= rate_in;
            write_val_reg <= hold ? prev_avg_reg : rate_in;
            refill_reg    <= refill;
        end
        if (cmd.mul_step)
        begin
            avg_reg <= quo_avg;
            v_reg   <= factor_prod[PROD_W-1:FACTOR_FRAC];
        end
        if (cmd.scale_step)
        begin
            scaled_reg    <= v_less_bg;
            unit_prod_reg <= UNIT_PROD_W'(v_less_bg) * UNIT_PROD_W'(UNIT1_NUM);
        end
        if (cmd.load_result)
        begin
            avg_out_reg      <= avg_reg;
            disp_out_reg     <= disp_comb;
            refilled_out_reg <= refill_reg;
        end
    end

    always_comb
    begin
        status.fill_last   = (fill_idx_reg == LAST_IDX);
        status.refill      = refill_reg;
        status.unit_one    = (cfg.unit == UNIT_SVH);
        status.div_idle    = div_idle;
        status.result_free = !result_valid_reg || result_ready;
    end

    assign result_valid    = result_valid_reg;
    assign average_rate    = avg_out_reg;
    assign display_value   = disp_out_reg;
    assign window_refilled = refilled_out_reg;

    `ACRA_ASSERT(a_wp_in_window, wp_reg <= LAST_IDX, "write pointer left the window")
    `ACRA_ASSERT(a_cnt_limit, (rise_cnt_reg <= LIMIT[CNT_W-1:0]) && (fall_cnt_reg <= LIMIT[CNT_W-1:0]) && (ret_cnt_reg <= LIMIT[CNT_W-1:0]), "fast counter above limit")
    `ACRA_ASSERT(a_one_counter, $onehot0({rise_cnt_reg != '0, fall_cnt_reg != '0, ret_cnt_reg != '0}), "more than one fast counter running")

endmodule

@@ src/acra_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: sequences ring update or refill, averaging, scaling and
// result hand-off. Depends on acra_pkg.
`include "assert_macros.svh"

module acra_ctrl
    import acra_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pulse_valid,
    output logic    pulse_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (status.fill_last)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (pulse_valid)
                    state_next = ST_UPDATE;
            ST_UPDATE:
                state_next = status.refill ? ST_FILL : ST_AVG_START;
            ST_FILL:
                if (status.fill_last)
                    state_next = ST_AVG_START;
            ST_AVG_START:
                state_next = ST_AVG_WAIT;
            ST_AVG_WAIT:
                if (status.div_idle)
                    state_next = ST_MUL;
            ST_MUL:
                state_next = ST_SCALE;
            ST_SCALE:
                state_next = status.unit_one ? ST_UNIT_START : ST_OUT;
            ST_UNIT_START:
                state_next = ST_UNIT_WAIT;
            ST_UNIT_WAIT:
                if (status.div_idle)
                    state_next = ST_OUT;
            ST_OUT:
                if (status.result_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.accept      = (state_reg == ST_IDLE) && pulse_valid;
        cmd.clear_step  = (state_reg == ST_CLEAR);
        cmd.ring_write  = (state_reg == ST_UPDATE) && !status.refill;
        cmd.fill_step   = (state_reg == ST_FILL);
        cmd.div_start   = (state_reg == ST_AVG_START) || (state_reg == ST_UNIT_START);
        cmd.div_unit    = (state_reg == ST_UNIT_START);
        cmd.mul_step    = (state_reg == ST_MUL);
        cmd.scale_step  = (state_reg == ST_SCALE);
        cmd.load_result = (state_reg == ST_OUT) && status.result_free;
        pulse_ready     = (state_reg == ST_IDLE);
    end

    `ACRA_ASSERT(a_idle_div_free, (state_reg == ST_IDLE) |-> status.div_idle, "divider busy while idle")
    `ACRA_ASSERT(a_avg_after_div, (state_reg == ST_MUL) |-> ($past(state_reg) == ST_AVG_WAIT), "average taken without divide")

endmodule

@@ src/adaptive_count_rate_averager_core.sv @@
`timescale 1ns / 1ps
// Top level of the adaptive count-rate averager: APB register file,
// controller and datapath. Depends on acra_pkg, acra_ctrl and acra_dp.

// Each item is one second's pulse count; each produces one result with the
// windowed average (Q20.8), the converted display reading (Q24.8, saturated)
// and a flag for a full window refill. An item goes from acceptance through
// the ring update, a refill of the whole window when it refills, the divide
// by the window length, the factor multiply, the background subtraction and,
// when unit is 1, the scaling by 116/100 to a loaded result; the next item is
// accepted only after the result loads. The division by the window length
// and the division by 100 share one constant divider, a reciprocal multiply;
// the refill walks the ring memory one entry per cycle. After reset the ring
// is cleared in one pass over its entries, during which pulse_ready stays
// low; register writes are taken at any time. A finished result waits in the
// output register, and the next item is accepted while it does; the block
// holds in its last step until that register is free again.
module adaptive_count_rate_averager_core
    import acra_pkg::*;
#(
    parameter int WINDOW_LENGTH = DEF_WINDOW_LENGTH,
    parameter int FAST_LIMIT    = DEF_FAST_LIMIT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    // input items
    input  logic                  pulse_valid,
    output logic                  pulse_ready,
    input  logic [COUNT_W-1:0]    pulse_count,
    // result items
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [RATE_W-1:0]     average_rate,
    output logic [DISP_W-1:0]     display_value,
    output logic                  window_refilled
);

    logic [COUNT_W-1:0]  threshold_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic [BG_W-1:0]     background_reg;
    logic [UNIT_W-1:0]   unit_reg;
    logic                reg_write;
    reg_idx_t            reg_idx;
    cfg_t                cfg;
    cmd_t                cmd;
    status_t             status;

    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;
    assign reg_idx   = reg_idx_t'(paddr[REG_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RST;
            factor_reg     <= FACTOR_RST;
            background_reg <= BACKGROUND_RST;
            unit_reg       <= UNIT_CPS;
        end
        else if (reg_write)
        begin
            unique case (reg_idx)
                REG_THRESHOLD:  threshold_reg  <= pwdata[COUNT_W-1:0];
                REG_FACTOR:     factor_reg     <= pwdata[FACTOR_W-1:0];
                REG_BACKGROUND: background_reg <= pwdata[BG_W-1:0];
                REG_UNIT:       unit_reg       <= pwdata[UNIT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_THRESHOLD:  prdata = DATA_W'(threshold_reg);
            REG_FACTOR:     prdata = DATA_W'(factor_reg);
            REG_BACKGROUND: prdata = DATA_W'(background_reg);
            REG_UNIT:       prdata = DATA_W'(unit_reg);
        endcase
    end

    always_comb
    begin
        cfg.threshold  = threshold_reg;
        cfg.factor     = factor_reg;
        cfg.background = background_reg;
        cfg.unit       = unit_reg;
    end

    acra_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .pulse_valid(pulse_valid),
        .pulse_ready(pulse_ready),
        .status     (status),
        .cmd        (cmd)
    );

    acra_dp #(
        .WINDOW_LENGTH(WINDOW_LENGTH),
        .FAST_LIMIT   (FAST_LIMIT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg            (cfg),
        .pulse_count    (pulse_count),
        .result_ready   (result_ready),
        .result_valid   (result_valid),
        .average_rate   (average_rate),
        .display_value  (display_value),
        .window_refilled(window_refilled)
    );

endmodule

@@ dv/adaptive_count_rate_averager_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for adaptive_count_rate_averager_core: directed table
// plus scenario-driven random counts, checked against an in-bench predictor.
// Depends on acra_pkg and the core RTL only.
module adaptive_count_rate_averager_core_tb;
    import acra_pkg::*;

    localparam int unsigned WIN        = DEF_WINDOW_LENGTH;
    localparam int unsigned HOLD_LIMIT = DEF_FAST_LIMIT;
    localparam int unsigned COUNT_MAX  = (1 << COUNT_W) - 1;
    localparam logic [UNIT_W-1:0] UNIT_SPARE = 2'd3;

    typedef struct packed {
        logic [RATE_W-1:0] avg;
        logic [DISP_W-1:0] disp;
        logic              refill;
    } reading_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               typed;
        reading_t           rd;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [REG_ADDR_W-1:0] paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  pulse_valid;
    logic                  pulse_ready;
    logic [COUNT_W-1:0]    pulse_count;
    logic                  result_valid;
    logic                  result_ready;
    logic [RATE_W-1:0]     average_rate;
    logic [DISP_W-1:0]     display_value;
    logic                  window_refilled;

    adaptive_count_rate_averager_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .pulse_valid     (pulse_valid),
        .pulse_ready     (pulse_ready),
        .pulse_count     (pulse_count),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .average_rate    (average_rate),
        .display_value   (display_value),
        .window_refilled (window_refilled)
    );

    // averager state as the block should hold it
    logic [RATE_W-1:0] ring_m [WIN];
    int unsigned       wp_m = 0;
    logic [33:0]       sum_m = '0;
    logic [RATE_W-1:0] prev_avg_m = '0;
    logic [CNT_W-1:0]  rise_n = '0;
    logic [CNT_W-1:0]  fall_n = '0;
    logic [CNT_W-1:0]  return_n = '0;

    logic [COUNT_W-1:0]  thr_cfg    = THRESHOLD_RST;
    logic [FACTOR_W-1:0] factor_cfg = FACTOR_RST;
    logic [BG_W-1:0]     bg_cfg     = BACKGROUND_RST;
    logic [UNIT_W-1:0]   unit_cfg   = UNIT_CPS;

    reading_t      expected_readings [$];
    directed_row_t dir_rows [$];
    reading_t      no_reading = '0;
    int unsigned   error_count = 0;
    int unsigned   burst_left = 0;
    logic          valid_held = 1'b0;
    int unsigned   level = 100;
    int unsigned   stall_tick = 0;
    int unsigned   stall_mode = 0;

    initial begin
        for (int i = 0; i < WIN; i++)
            ring_m[i] = '0;
    end

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("tb: mismatch %s: got %0h, want %0h", what, got, want);
        error_count++;
    endtask

    function automatic void ring_put(input logic [RATE_W-1:0] v);
        sum_m = sum_m - ring_m[wp_m] + v;
        ring_m[wp_m] = v;
        wp_m = (wp_m + 1 == WIN) ? 0 : wp_m + 1;
    endfunction

    // Hold the previous average for one more second, or refill the ring
    // once the run of held seconds goes past the limit.
    function automatic logic hold_second(input logic [CNT_W-1:0] held_n,
                                         input logic [RATE_W-1:0] rate,
                                         input logic [RATE_W-1:0] prev);
        if (int'(held_n) + 1 > HOLD_LIMIT) begin
            for (int i = 0; i < WIN; i++)
                ring_m[i] = rate;
            sum_m = {6'd0, rate} * 34'(WIN);
            return 1'b1;
        end
        ring_put(prev);
        return 1'b0;
    endfunction

    function automatic reading_t predict_reading(input logic [COUNT_W-1:0] count);
        logic [RATE_W-1:0] rate;
        logic [RATE_W-1:0] prev;
        logic [63:0]       scaled;
        logic [63:0]       shown;
        reading_t          rd;
        rate = {count, 8'h00};
        prev = prev_avg_m;
        rd.refill = 1'b0;
        if (count < thr_cfg) begin
            rise_n = '0;
            fall_n = '0;
            if (prev > {thr_cfg, 8'h00}) begin
                rd.refill = hold_second(return_n, rate, prev);
                return_n = rd.refill ? '0 : return_n + 1'b1;
            end else begin
                ring_put(rate);
            end
        end else begin
            return_n = '0;
            if (64'(rate) * 10 > 64'(prev) * 13) begin
                fall_n = '0;
                rd.refill = hold_second(rise_n, rate, prev);
                rise_n = rd.refill ? '0 : rise_n + 1'b1;
            end else if (64'(rate) * 10 < 64'(prev) * 7) begin
                rise_n = '0;
                rd.refill = hold_second(fall_n, rate, prev);
                fall_n = rd.refill ? '0 : fall_n + 1'b1;
            end else begin
                ring_put(rate);
            end
        end
        rd.avg = RATE_W'(sum_m / WIN);
        prev_avg_m = rd.avg;

        scaled = (64'(rd.avg) * 64'(factor_cfg)) >> 16;
        if (scaled > 64'(bg_cfg))
            scaled = scaled - 64'(bg_cfg);
        if (unit_cfg == UNIT_CPS)
            shown = 64'(rd.avg);
        else if (unit_cfg == UNIT_SVH)
            shown = scaled * 116 / 100;
        else
            shown = scaled;
        rd.disp = (shown > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : shown[31:0];
        return rd;
    endfunction

    function automatic directed_row_t row_of(input logic [COUNT_W-1:0] count,
                                             input logic typed,
                                             input logic [RATE_W-1:0] avg,
                                             input logic [DISP_W-1:0] disp,
                                             input logic refill);
        directed_row_t r;
        r.count     = count;
        r.typed     = typed;
        r.rd.avg    = avg;
        r.rd.disp   = disp;
        r.rd.refill = refill;
        return r;
    endfunction

    task automatic apb_transfer(input logic wr, input reg_idx_t idx,
                                input logic [DATA_W-1:0] wdata,
                                output logic [DATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_register(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] readback;
        case (idx)
            REG_THRESHOLD: begin
                mask = {DATA_W{1'b1}} >> (DATA_W - COUNT_W);
                thr_cfg = value[COUNT_W-1:0];
            end
            REG_FACTOR: begin
                mask = {DATA_W{1'b1}} >> (DATA_W - FACTOR_W);
                factor_cfg = value[FACTOR_W-1:0];
            end
            REG_BACKGROUND: begin
                mask = {DATA_W{1'b1}};
                bg_cfg = value[BG_W-1:0];
            end
            default: begin
                mask = {DATA_W{1'b1}} >> (DATA_W - UNIT_W);
                unit_cfg = value[UNIT_W-1:0];
            end
        endcase
        apb_transfer(1'b1, idx, value, readback);
        apb_transfer(1'b0, idx, '0, readback);
        if ((readback & mask) != (value & mask))
            report_mismatch("register readback", readback & mask, value & mask);
    endtask

    // Drop valid if it is held and wait until every result is back.
    task automatic wait_drained();
        if (valid_held) begin
            pulse_valid <= 1'b0;
            valid_held = 1'b0;
        end
        while (expected_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [COUNT_W-1:0] thr,
                              input logic [FACTOR_W-1:0] factor,
                              input logic [BG_W-1:0] bg,
                              input logic [UNIT_W-1:0] unit);
        wait_drained();
        set_register(REG_THRESHOLD, DATA_W'(thr));
        set_register(REG_FACTOR, DATA_W'(factor));
        set_register(REG_BACKGROUND, DATA_W'(bg));
        set_register(REG_UNIT, DATA_W'(unit));
    endtask

    task automatic send_item(input logic [COUNT_W-1:0] count, input logic typed,
                             input reading_t typed_rd);
        reading_t rd;
        pulse_valid <= 1'b1;
        pulse_count <= count;
        do @(posedge clk); while (!pulse_ready);
        rd = predict_reading(count);
        expected_readings.push_back(typed ? typed_rd : rd);
        if (burst_left > 0) begin
            burst_left--;
            valid_held = 1'b1;
        end else begin
            pulse_valid <= 1'b0;
            valid_held = 1'b0;
            if ($urandom_range(0, 29) == 0) begin
                // hold off until the block has nothing left in flight
                while (expected_readings.size() != 0)
                    @(posedge clk);
            end
            repeat ($urandom_range(1, 20)) @(posedge clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    // Mostly runs of counts around a level, with sustained jumps up and down
    // and dips below the threshold; a little pure noise on top.
    task automatic run_random(input int unsigned n_items);
        int unsigned sent;
        int unsigned kind;
        int unsigned run;
        int unsigned c;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            run  = $urandom_range(3, 9);
            if (kind == 8 && thr_cfg == 0)
                kind = 9;
            case (kind)
                3: level = $urandom_range(0, COUNT_MAX) >> $urandom_range(0, 19);
                4, 5: begin
                    level = level * 2 + $urandom_range(1, 64);
                    if (level > COUNT_MAX)
                        level = COUNT_MAX;
                end
                6, 7: level = level / $urandom_range(2, 5);
                9: run = $urandom_range(1, 3);
                default: ;
            endcase
            for (int k = 0; k < run; k++) begin
                if (kind == 8)
                    c = $urandom_range(0, thr_cfg - 1);
                else if (kind == 9)
                    c = $urandom & COUNT_MAX;
                else
                    c = level - level / 16 + $urandom_range(0, level / 8);
                if (c > COUNT_MAX)
                    c = COUNT_MAX;
                send_item(c[COUNT_W-1:0], 1'b0, no_reading);
                sent++;
            end
        end
    endtask

    // receiver: stall pattern redrawn at random among four modes
    always @(posedge clk) begin
        stall_tick++;
        if (stall_tick % 300 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: result_ready <= 1'b1;
            1: result_ready <= $urandom_range(0, 1);
            2: result_ready <= ($urandom_range(0, 7) == 0);
            default: result_ready <= ~result_ready;
        endcase
    end

    always @(posedge clk) begin : result_check
        reading_t want;
        if (rst_n && result_valid && result_ready) begin
            if (expected_readings.size() == 0) begin
                report_mismatch("result with none pending", average_rate, 0);
            end else begin
                want = expected_readings.pop_front();
                if (average_rate !== want.avg)
                    report_mismatch("average_rate", average_rate, want.avg);
                if (display_value !== want.disp)
                    report_mismatch("display_value", display_value, want.disp);
                if (window_refilled !== want.refill)
                    report_mismatch("window_refilled", window_refilled, want.refill);
            end
        end
    end

    initial begin : stimulus
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        pulse_valid  = 1'b0;
        pulse_count  = '0;
        result_ready = 1'b0;

        // defaults: threshold 10, factor 1.0, no background, counts per second
        dir_rows.push_back(row_of(20'd0, 1'b1, 28'd0, 32'd0, 1'b0));
        // sustained rise from an empty window: five held seconds, then refill
        for (int i = 0; i < 5; i++)
            dir_rows.push_back(row_of(20'hFFFFF, 1'b1, 28'd0, 32'd0, 1'b0));
        dir_rows.push_back(row_of(20'hFFFFF, 1'b1, 28'hFFFFF00, 32'h0FFFFF00, 1'b1));
        // quiet seconds under a high average: hold, then refill with zero
        for (int i = 0; i < 5; i++)
            dir_rows.push_back(row_of(20'd0, 1'b1, 28'hFFFFF00, 32'h0FFFFF00, 1'b0));
        dir_rows.push_back(row_of(20'd0, 1'b1, 28'd0, 32'd0, 1'b1));
        for (int i = 0; i < 6; i++)
            dir_rows.push_back(row_of(20'd100, 1'b0, '0, '0, 1'b0));
        // sustained fall with the count exactly at the threshold
        for (int i = 0; i < 6; i++)
            dir_rows.push_back(row_of(20'd10, 1'b0, '0, '0, 1'b0));
        // exactly 1.3 times the average is not a rise
        dir_rows.push_back(row_of(20'd13, 1'b0, '0, '0, 1'b0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < dir_rows.size(); i++)
            send_item(dir_rows[i].count, dir_rows[i].typed, dir_rows[i].rd);

        set_config(20'd0, 24'hFFFFFF, 32'd0, UNIT_SVH);
        run_random(80);
        set_config(20'hFFFFF, 24'd0, 32'hFFFF_FFFF, UNIT_SCALED);
        run_random(80);
        set_config($urandom_range(1, 400), $urandom & 24'hFFFFFF,
                   $urandom_range(0, 4096), UNIT_SVH);
        run_random(80);
        set_config($urandom_range(1, 2000), 24'h030000, $urandom, UNIT_SPARE);
        run_random(80);
        set_config($urandom & 20'hFFFFF, $urandom & 24'hFFFFFF,
                   $urandom_range(0, 1 << 20), UNIT_CPS);
        run_random(80);

        wait_drained();
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
